### rtl/core/sli_pkg.sv
// Shared types and constants for the sorted insertion list.
package sli_pkg;

   localparam int DATA_W = 32;
   localparam int POS_W  = 4;

   typedef logic signed [DATA_W-1:0] data_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_ROT_LEFT,
      CELL_ROT_RIGHT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      data_type    new_value;
   } cell_ctrl_type;

endpackage

### rtl/core/sli_cell.sv
// One storage cell of the sorted list ring: compare, insert shift and rotate.
module sli_cell
   import sli_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic [CNT_W-1:0] count,
   input  data_type      prev_value,
   input  logic          prev_gt,
   input  data_type      next_value,
   output data_type      value,
   output logic          gt
);

   data_type value_ff;
   data_type value_in;
   logic     occupied;
   logic     at_end;

   assign occupied = CNT_W'(INDEX) < count;
   assign at_end   = CNT_W'(INDEX) == count;
   assign gt       = occupied && (value_ff > ctrl.new_value);
   assign value    = value_ff;

   always_comb begin
      value_in = value_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            // shift up behind the insertion point, take the new value at it
            if (prev_gt) begin
               value_in = prev_value;
            end else if (gt || at_end) begin
               value_in = ctrl.new_value;
            end
         end
         CELL_ROT_LEFT:  value_in = next_value;
         CELL_ROT_RIGHT: value_in = prev_value;
         default:        value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

### rtl/core/sorted_list_insert_core.sv
// Sorted insertion list: each item enters a ring of cells, then the list is emitted both ways.
// The first result appears the cycle after the transfer; insertion takes place at that edge.
// An item holding n stored values (after insert) yields 2n results as the cell ring rotates
// left then right, one per cycle; busy is high while they are emitted.
// Start is taken only while idle; a full list drops the item and flags rsp_overflow.
// Reset clears the entry count and control; cell contents stay undefined until written.
module sorted_list_insert_core
   import sli_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic signed [DATA_W-1:0] req_value,
   output logic             rsp_valid,
   output logic signed [DATA_W-1:0] rsp_element,
   output logic [POS_W-1:0] rsp_position,
   output logic             rsp_descending,
   output logic             rsp_overflow,
   output logic             rsp_last
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ASC,
      ST_DESC
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] count_ff;
   logic [IDX_W-1:0] pos_ff;
   logic             ovf_ff;

   logic             accept;
   logic             full;
   cell_ctrl_type    ctrl;
   data_type         cell_value [DEPTH];
   logic             cell_gt    [DEPTH];

   assign accept = start && (state_ff == ST_IDLE);
   assign full   = count_ff == CNT_W'(DEPTH);

   always_comb begin
      ctrl.new_value = req_value;
      case (state_ff)
         ST_IDLE: ctrl.op = (accept && !full) ? CELL_INSERT : CELL_HOLD;
         ST_ASC:  ctrl.op = CELL_ROT_LEFT;
         ST_DESC: ctrl.op = CELL_ROT_RIGHT;
         default: ctrl.op = CELL_HOLD;
      endcase
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam int PREV = (i == 0) ? DEPTH - 1 : i - 1;
      localparam int NEXT = (i == DEPTH - 1) ? 0 : i + 1;

      sli_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .count      (count_ff),
         .prev_value (cell_value[PREV]),
         .prev_gt    ((i == 0) ? 1'b0 : cell_gt[PREV]),
         .next_value (cell_value[NEXT]),
         .value      (cell_value[i]),
         .gt         (cell_gt[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pos_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  ovf_ff   <= full;
                  pos_ff   <= '0;
                  state_ff <= ST_ASC;
                  if (!full) begin
                     count_ff <= count_ff + CNT_W'(1);
                  end
               end
            end
            ST_ASC: begin
               // hold position at the top element for the first descending result
               if (CNT_W'(pos_ff) == count_ff - CNT_W'(1)) begin
                  state_ff <= ST_DESC;
               end else begin
                  pos_ff <= pos_ff + IDX_W'(1);
               end
            end
            ST_DESC: begin
               if (pos_ff == '0) begin
                  state_ff <= ST_IDLE;
               end else begin
                  pos_ff <= pos_ff - IDX_W'(1);
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy           = state_ff != ST_IDLE;
   assign rsp_valid      = busy;
   assign rsp_descending = state_ff == ST_DESC;
   assign rsp_element    = rsp_descending ? cell_value[DEPTH-1] : cell_value[0];
   assign rsp_position   = POS_W'(pos_ff);
   assign rsp_overflow   = ovf_ff;
   assign rsp_last       = rsp_descending && (pos_ff == '0);

endmodule

### rtl/core/sli_checker.sv
// Port-level checks for the sorted insertion list, bound to the top level.
module sli_checker
   import sli_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input logic [POS_W-1:0] rsp_position,
   input logic             rsp_descending,
   input logic             rsp_overflow,
   input logic             rsp_last
);

   a_first_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && rsp_valid && !rsp_descending && rsp_position == '0)
      else $error("first result does not follow the transfer");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid && !busy)
      else $error("results continue after last");

   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_descending && rsp_position == '0)
      else $error("last result not at position zero of descending pass");

   a_desc_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_descending && !rsp_last |=>
         rsp_valid && rsp_descending && rsp_position == $past(rsp_position) - 4'd1
         && rsp_overflow == $past(rsp_overflow))
      else $error("descending pass skipped a position");

endmodule

bind sorted_list_insert_core sli_checker u_sli_checker (.*);
